>>> src/mf3_pkg.sv
// Shared types and constants for the 3x3 median filter stream unit.
`timescale 1ns / 1ps
`default_nettype none
package mf3_pkg;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 11;
    localparam int CFG_W     = 12;
    localparam int MAX_COLS  = 2048;
    localparam int MAX_ROWS  = 4095;
    localparam int MIN_DIM   = 3;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    localparam int Q_DEPTH   = 4;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH) + 1;
    localparam int OUT_DEPTH = 8;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH) + 1;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             border;
        logic             median;
    } t_item;

    typedef struct packed {
        logic [COL_W-1:0] median_col;
        logic [ROW_W-1:0] median_row;
        logic [PIX_W-1:0] median_value;
        logic             median_valid;
        logic [COL_W-1:0] border_col;
        logic [ROW_W-1:0] border_row;
        logic [PIX_W-1:0] border_value;
        logic             border_valid;
    } t_result;

endpackage
`default_nettype wire

>>> src/median_filter_3x3_stream_unit.sv
// Top level of the 3x3 median filter on a raster pixel stream.
// Throughput: one pixel per clock while m_axis_tready is high; one result per pixel.
// Path: an accepted pixel passes the request queue, the registered line store read, the
// sorting network stages s1, s2 and s3 and the output queue before its result shows.
// Reset is synchronous and active low: position counters go to zero, the frame size
// returns to 640 by 480 and both queues empty; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module median_filter_3x3_stream_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [mf3_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // pixel_in
    input  wire logic [0:0]                    s_axis_tuser,   // frame_start
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // border_value, border_row, border_col, median_value, median_row, median_col, zero pad
    output logic [63:0]                        m_axis_tdata,
    output logic [1:0]                         m_axis_tuser    // border_valid, median_valid
);

    mf3_pkg::t_item                     front_item, q_item;
    logic                               front_push, q_pop;
    logic [mf3_pkg::Q_CNT_W-1:0]        q_count;
    mf3_pkg::t_result                   back_result, out_result;
    logic                               out_push, out_pop;
    logic [mf3_pkg::OUT_CNT_W-1:0]      out_count;

    mf3_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (s_axis_tvalid),
        .i_pixel      (s_axis_tdata),
        .i_frame_start(s_axis_tuser[0]),
        .i_q_count    (q_count),
        .o_ready      (s_axis_tready),
        .o_push       (front_push),
        .o_item       (front_item)
    );

    mf3_fifo #(
        .WIDTH($bits(mf3_pkg::t_item)),
        .DEPTH(mf3_pkg::Q_DEPTH)
    ) u_req_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_data (front_item),
        .i_pop  (q_pop),
        .o_data (q_item),
        .o_count(q_count)
    );

    mf3_back #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_item   (q_item),
        .i_q_count  (q_count),
        .o_q_pop    (q_pop),
        .i_out_count(out_count),
        .o_out_push (out_push),
        .o_out_data (back_result)
    );

    mf3_fifo #(
        .WIDTH($bits(mf3_pkg::t_result)),
        .DEPTH(mf3_pkg::OUT_DEPTH)
    ) u_out_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data (back_result),
        .i_pop  (out_pop),
        .o_data (out_result),
        .o_count(out_count)
    );

    assign m_axis_tvalid = (out_count != '0);
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tuser  = {out_result.median_valid, out_result.border_valid};
    assign m_axis_tdata  = {2'b00,
                            out_result.median_col,
                            out_result.median_row,
                            out_result.median_value,
                            out_result.border_col,
                            out_result.border_row,
                            out_result.border_value};

endmodule
`default_nettype wire

>>> src/mf3_fifo.sv
// Small first-word-fall-through queue built from flip-flops.
`timescale 1ns / 1ps
`default_nettype none
module mf3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic      [WIDTH-1:0]           o_data,
    output logic      [$clog2(DEPTH):0]     o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH) + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

endmodule
`default_nettype wire

>>> src/mf3_front.sv
// Front end: configuration registers, raster position tracking and border and median classification.
`timescale 1ns / 1ps
`default_nettype none
module mf3_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [mf3_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_valid,
    input  wire logic [mf3_pkg::PIX_W-1:0]     i_pixel,
    input  wire logic                          i_frame_start,
    input  wire logic [mf3_pkg::Q_CNT_W-1:0]   i_q_count,
    output logic                               o_ready,
    output logic                               o_push,
    output mf3_pkg::t_item                     o_item
);

    localparam int CW = mf3_pkg::CFG_W;
    localparam int RW = mf3_pkg::ROW_W;
    localparam int KW = mf3_pkg::COL_W;
    localparam int CAP = (MAX_WIDTH < mf3_pkg::MAX_COLS) ? MAX_WIDTH : mf3_pkg::MAX_COLS;

    logic [CW-1:0] r_width, r_height;
    logic [KW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] w_eff, h_eff;
    logic [KW-1:0] col0, col1;
    logic [RW-1:0] row0, row_c;
    logic [RW:0]   row1, row_inc;
    logic [KW:0]   col_inc;
    logic          accept;

    always_comb begin
        w_eff = r_width;
        if (r_width < CW'(mf3_pkg::MIN_DIM)) begin
            w_eff = CW'(mf3_pkg::MIN_DIM);
        end else if (r_width > CW'(CAP)) begin
            w_eff = CW'(CAP);
        end
        h_eff = r_height;
        if (r_height < CW'(mf3_pkg::MIN_DIM)) begin
            h_eff = CW'(mf3_pkg::MIN_DIM);
        end else if (r_height > CW'(mf3_pkg::MAX_ROWS)) begin
            h_eff = CW'(mf3_pkg::MAX_ROWS);
        end
    end

    assign o_ready = (i_q_count < mf3_pkg::Q_CNT_W'(mf3_pkg::Q_DEPTH));
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        col0 = i_frame_start ? '0 : r_col;
        row0 = i_frame_start ? '0 : r_row;
        if ({1'b0, col0} >= w_eff) begin
            col1 = '0;
            row1 = {1'b0, row0} + (RW+1)'(1);
        end else begin
            col1 = col0;
            row1 = {1'b0, row0};
        end
        row_c = (row1 >= {1'b0, h_eff}) ? '0 : row1[RW-1:0];

        col_inc = {1'b0, col1} + (KW+1)'(1);
        row_inc = {1'b0, row_c} + (RW+1)'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[RW-1:0];
        end else begin
            n_col = col_inc[KW-1:0];
            n_row = row_c;
        end

        o_item.pixel  = i_pixel;
        o_item.row    = row_c;
        o_item.col    = col1;
        o_item.border = (row_c == '0) || (row_c == h_eff - CW'(1)) ||
                        (col1 == '0) || ({1'b0, col1} == w_eff - CW'(1));
        o_item.median = (row_c >= RW'(2)) && (col1 >= KW'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CW'(mf3_pkg::WIDTH_RST);
            r_height <= CW'(mf3_pkg::HEIGHT_RST);
        end else if (i_cfg_wr_en) begin
            case (mf3_pkg::t_cfg_index'(i_cfg_index))
                mf3_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata;
                mf3_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (({1'b0, o_item.col} < w_eff) && (o_item.row < h_eff)))
        else $error("request position outside the frame");

endmodule
`default_nettype wire

>>> src/mf3_back.sv
// Back end: line store, 3x3 window and pipelined median-of-nine network.
`timescale 1ns / 1ps
`default_nettype none
module mf3_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire mf3_pkg::t_item                  i_q_item,
    input  wire logic [mf3_pkg::Q_CNT_W-1:0]     i_q_count,
    output logic                                 o_q_pop,
    input  wire logic [mf3_pkg::OUT_CNT_W-1:0]   i_out_count,
    output logic                                 o_out_push,
    output mf3_pkg::t_result                     o_out_data
);

    localparam int PW = mf3_pkg::PIX_W;
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW = mf3_pkg::OUT_CNT_W + 1;

    function automatic logic [2*PW-1:0] f_sort2(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return (a > b) ? {a, b} : {b, a};
    endfunction

    // Each entry holds the upper row in the high byte and the middle row in the low byte.
    logic [2*PW-1:0] r_mem [MAX_WIDTH];
    logic [2*PW-1:0] r_rd, r_fwd_data;
    logic            r_fwd;
    logic            r_a_valid;
    mf3_pkg::t_item  r_a_item;
    logic            r_s1_valid, r_s2_valid;
    mf3_pkg::t_item  r_s1_item, r_s2_item;
    logic [PW-1:0]   r_s1_v [9];
    logic [PW-1:0]   r_s2_v [9];
    logic [PW-1:0]   r_win  [6];
    logic [PW-1:0]   n_s1_v [9];
    logic [PW-1:0]   n_s2_v [9];
    logic [PW-1:0]   s3     [9];
    logic [2*PW-1:0] line_rd, line_wr;
    logic [AW-1:0]   q_addr, a_addr;
    logic [SW-1:0]   in_flight;

    assign in_flight = SW'(i_out_count) + SW'(r_a_valid) + SW'(r_s1_valid) + SW'(r_s2_valid);
    assign o_q_pop   = (i_q_count != '0) && (in_flight < SW'(mf3_pkg::OUT_DEPTH));
    assign q_addr    = AW'(i_q_item.col);
    assign a_addr    = AW'(r_a_item.col);
    assign line_rd   = r_fwd ? r_fwd_data : r_rd;
    assign line_wr   = {line_rd[PW-1:0], r_a_item.pixel};

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_mem[a_addr] <= line_wr;
        end
        if (o_q_pop) begin
            r_rd       <= r_mem[q_addr];
            r_fwd      <= r_a_valid && (a_addr == q_addr);
            r_fwd_data <= line_wr;
            r_a_item   <= i_q_item;
        end
        if (r_a_valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= line_rd[2*PW-1:PW];
            r_win[4] <= line_rd[PW-1:0];
            r_win[5] <= r_a_item.pixel;
        end
        r_s1_item <= r_a_item;
        r_s1_v    <= n_s1_v;
        r_s2_item <= r_s1_item;
        r_s2_v    <= n_s2_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_a_valid  <= o_q_pop;
            r_s1_valid <= r_a_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_s1_v[k] = r_win[k];
        end
        n_s1_v[6] = line_rd[2*PW-1:PW];
        n_s1_v[7] = line_rd[PW-1:0];
        n_s1_v[8] = r_a_item.pixel;
        {n_s1_v[2], n_s1_v[1]} = f_sort2(n_s1_v[1], n_s1_v[2]);
        {n_s1_v[5], n_s1_v[4]} = f_sort2(n_s1_v[4], n_s1_v[5]);
        {n_s1_v[8], n_s1_v[7]} = f_sort2(n_s1_v[7], n_s1_v[8]);
        {n_s1_v[1], n_s1_v[0]} = f_sort2(n_s1_v[0], n_s1_v[1]);
        {n_s1_v[4], n_s1_v[3]} = f_sort2(n_s1_v[3], n_s1_v[4]);
        {n_s1_v[7], n_s1_v[6]} = f_sort2(n_s1_v[6], n_s1_v[7]);
        {n_s1_v[2], n_s1_v[1]} = f_sort2(n_s1_v[1], n_s1_v[2]);
        {n_s1_v[5], n_s1_v[4]} = f_sort2(n_s1_v[4], n_s1_v[5]);
        {n_s1_v[8], n_s1_v[7]} = f_sort2(n_s1_v[7], n_s1_v[8]);
    end

    always_comb begin
        n_s2_v = r_s1_v;
        {n_s2_v[3], n_s2_v[0]} = f_sort2(n_s2_v[0], n_s2_v[3]);
        {n_s2_v[8], n_s2_v[5]} = f_sort2(n_s2_v[5], n_s2_v[8]);
        {n_s2_v[7], n_s2_v[4]} = f_sort2(n_s2_v[4], n_s2_v[7]);
        {n_s2_v[6], n_s2_v[3]} = f_sort2(n_s2_v[3], n_s2_v[6]);
        {n_s2_v[4], n_s2_v[1]} = f_sort2(n_s2_v[1], n_s2_v[4]);
        {n_s2_v[5], n_s2_v[2]} = f_sort2(n_s2_v[2], n_s2_v[5]);
        {n_s2_v[7], n_s2_v[4]} = f_sort2(n_s2_v[4], n_s2_v[7]);
    end

    always_comb begin
        s3 = r_s2_v;
        {s3[2], s3[4]} = f_sort2(s3[4], s3[2]);
        {s3[4], s3[6]} = f_sort2(s3[6], s3[4]);
        {s3[2], s3[4]} = f_sort2(s3[4], s3[2]);

        o_out_push = r_s2_valid;
        o_out_data = '0;
        if (r_s2_item.border) begin
            o_out_data.border_valid = 1'b1;
            o_out_data.border_value = r_s2_item.pixel;
            o_out_data.border_row   = r_s2_item.row;
            o_out_data.border_col   = r_s2_item.col;
        end
        if (r_s2_item.median) begin
            o_out_data.median_valid = 1'b1;
            o_out_data.median_value = s3[4];
            o_out_data.median_row   = r_s2_item.row - mf3_pkg::ROW_W'(1);
            o_out_data.median_col   = r_s2_item.col - mf3_pkg::COL_W'(1);
        end
    end

    a_pop_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_a_valid)
        else $error("popped request missing from the line store stage");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_flight <= SW'(mf3_pkg::OUT_DEPTH))
        else $error("results in flight exceed output queue space");

endmodule
`default_nettype wire
